[src/cqe_pkg.sv]
// Shared types and constants for the circular queue engine.
package cqe_pkg;

  localparam int unsigned DEPTH_DEF  = 8;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned SLOT_W     = 3;
  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned OUTQ_DEPTH = 4;

  // opcode field values
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_SHOW = 2'd2;

  // status field values
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_SHOW
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [WORD_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] data_word;
    logic [SLOT_W-1:0]        slot_index;
    logic                     last_of_run;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e                kind;
    logic signed [WORD_W-1:0] value;
  } cmd_t;

  // front to back command channel
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

endpackage

[src/cqe_fifo.sv]
// Small synchronous FIFO used for the command and result queues.
module cqe_fifo #(
  parameter int unsigned ENTRIES = cqe_pkg::CMDQ_DEPTH,
  parameter type item_t = logic,
  localparam int unsigned PTR_W = $clog2(ENTRIES),
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  item_t            item_i,
  input  logic             pop_i,
  output item_t            item_o,
  output logic             full_o,
  output logic             empty_o,
  output logic [CNT_W-1:0] count_o
);

  item_t            entries_q [ENTRIES];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(ENTRIES));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign item_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(ENTRIES - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(ENTRIES - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[src/cqe_front.sv]
// Front end: takes input transfers, decodes the opcode and queues commands.
module cqe_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cqe_pkg::in_item_t   in_item_i,
  output logic                full_o,
  output cqe_pkg::cmd_chan_t  cmd_chan_o,
  input  logic                cmd_pop_i
);

  cqe_pkg::cmd_t cmd_in;
  cqe_pkg::cmd_t cmd_out;
  logic          cmd_keep;
  logic          q_empty;

  // unused opcode is taken and dropped
  always_comb begin
    cmd_in.value = in_item_i.push_value;
    cmd_in.kind  = cqe_pkg::CMD_PUSH;
    cmd_keep     = 1'b1;
    unique case (in_item_i.opcode)
      cqe_pkg::OP_PUSH: cmd_in.kind = cqe_pkg::CMD_PUSH;
      cqe_pkg::OP_POP:  cmd_in.kind = cqe_pkg::CMD_POP;
      cqe_pkg::OP_SHOW: cmd_in.kind = cqe_pkg::CMD_SHOW;
      default:          cmd_keep    = 1'b0;
    endcase
  end

  cqe_fifo #(
    .ENTRIES (cqe_pkg::CMDQ_DEPTH),
    .item_t  (cqe_pkg::cmd_t)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i && cmd_keep),
    .item_i  (cmd_in),
    .pop_i   (cmd_pop_i),
    .item_o  (cmd_out),
    .full_o  (full_o),
    .empty_o (q_empty),
    .count_o ()
  );

  assign cmd_chan_o.valid = !q_empty;
  assign cmd_chan_o.cmd   = cmd_out;

endmodule

[src/cqe_back.sv]
// Back end: queue state, slot memory and result generation.
module cqe_back #(
  parameter int unsigned DEPTH = cqe_pkg::DEPTH_DEF,
  localparam int unsigned OCNT_W = $clog2(cqe_pkg::OUTQ_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cqe_pkg::cmd_chan_t  cmd_chan_i,
  output logic                cmd_pop_o,
  input  logic [OCNT_W-1:0]   out_cnt_i,
  output logic                out_push_o,
  output cqe_pkg::out_item_t  out_item_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = IDX_W + 1;
  localparam int unsigned SLOT_W = cqe_pkg::SLOT_W;
  localparam int unsigned WORD_W = cqe_pkg::WORD_W;

  typedef enum logic {
    BK_CMD,
    BK_SHOW
  } bk_state_e;

  bk_state_e                state_q, state_d;
  logic [IDX_W-1:0]         head_q, head_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [DEPTH-1:0]         valid_q, valid_d;
  logic [IDX_W-1:0]         show_idx_q, show_idx_d;

  // read stage
  logic                     b_valid_q;
  logic [1:0]               b_status_q;
  logic                     b_from_mem_q;
  logic                     b_hit_q;
  logic [SLOT_W-1:0]        b_slot_q;
  logic                     b_last_q;

  logic signed [WORD_W-1:0] mem_q [DEPTH];
  logic signed [WORD_W-1:0] rdata_q;

  logic                     room;
  logic                     is_full, is_empty;
  logic [SUM_W-1:0]         pos_sum;
  logic [IDX_W-1:0]         push_pos;
  logic [IDX_W-1:0]         head_nxt;
  logic [IDX_W-1:0]         rd_addr;
  logic [SLOT_W+IDX_W-1:0]  slot_ext;
  logic                     issue;
  logic                     mem_we;
  logic                     pop_ok;
  logic [1:0]               iss_status;
  logic                     iss_from_mem;
  logic [SLOT_W-1:0]        iss_slot;
  logic                     iss_last;

  // issue only if the result queue has space for everything in flight
  assign room = ((OCNT_W + 1)'(out_cnt_i) + (OCNT_W + 1)'(b_valid_q))
                < (OCNT_W + 1)'(cqe_pkg::OUTQ_DEPTH);

  assign is_full  = (count_q == CNT_W'(DEPTH));
  assign is_empty = (count_q == '0);
  assign pos_sum  = SUM_W'(head_q) + SUM_W'(count_q);
  assign push_pos = (pos_sum >= SUM_W'(DEPTH)) ? IDX_W'(pos_sum - SUM_W'(DEPTH))
                                               : IDX_W'(pos_sum);
  assign head_nxt = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign slot_ext = (SLOT_W + IDX_W)'(rd_addr);

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    valid_d      = valid_q;
    show_idx_d   = show_idx_q;
    rd_addr      = head_q;
    issue        = 1'b0;
    mem_we       = 1'b0;
    pop_ok       = 1'b0;
    cmd_pop_o    = 1'b0;
    iss_status   = cqe_pkg::ST_OK;
    iss_from_mem = 1'b0;
    iss_slot     = '0;
    iss_last     = 1'b1;
    unique case (state_q)
      BK_CMD: begin
        if (cmd_chan_i.valid && room) begin
          issue = 1'b1;
          unique case (cmd_chan_i.cmd.kind)
            cqe_pkg::CMD_PUSH: begin
              cmd_pop_o = 1'b1;
              if (is_full) begin
                iss_status = cqe_pkg::ST_FULL;
              end else begin
                mem_we            = 1'b1;
                valid_d[push_pos] = 1'b1;
                count_d           = count_q + 1'b1;
              end
            end
            cqe_pkg::CMD_POP: begin
              cmd_pop_o = 1'b1;
              if (is_empty) begin
                iss_status = cqe_pkg::ST_EMPTY;
              end else begin
                pop_ok          = 1'b1;
                iss_from_mem    = 1'b1;
                rd_addr         = head_q;
                valid_d[head_q] = 1'b0;
                head_d          = head_nxt;
                count_d         = count_q - 1'b1;
              end
            end
            cqe_pkg::CMD_SHOW: begin
              // first slot now, the rest from the show state
              rd_addr      = '0;
              iss_from_mem = 1'b1;
              iss_slot     = slot_ext[SLOT_W-1:0];
              iss_last     = 1'b0;
              show_idx_d   = IDX_W'(1);
              state_d      = BK_SHOW;
            end
            default: begin
              cmd_pop_o = 1'b1;
              issue     = 1'b0;
            end
          endcase
        end
      end
      BK_SHOW: begin
        rd_addr = show_idx_q;
        if (room) begin
          issue        = 1'b1;
          iss_from_mem = 1'b1;
          iss_slot     = slot_ext[SLOT_W-1:0];
          iss_last     = (show_idx_q == IDX_W'(DEPTH - 1));
          if (iss_last) begin
            cmd_pop_o  = 1'b1;
            show_idx_d = '0;
            state_d    = BK_CMD;
          end else begin
            show_idx_d = show_idx_q + 1'b1;
          end
        end
      end
      default: state_d = BK_CMD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_CMD;
      head_q       <= '0;
      count_q      <= '0;
      valid_q      <= '0;
      show_idx_q   <= '0;
      b_valid_q    <= 1'b0;
      b_status_q   <= cqe_pkg::ST_OK;
      b_from_mem_q <= 1'b0;
      b_hit_q      <= 1'b0;
      b_slot_q     <= '0;
      b_last_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      count_q      <= count_d;
      valid_q      <= valid_d;
      show_idx_q   <= show_idx_d;
      b_valid_q    <= issue;
      b_status_q   <= iss_status;
      b_from_mem_q <= iss_from_mem;
      b_hit_q      <= valid_q[rd_addr];
      b_slot_q     <= iss_slot;
      b_last_q     <= iss_last;
    end
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[push_pos] <= cmd_chan_i.cmd.value;
    end
    rdata_q <= mem_q[rd_addr];
  end

  // slots never written since reset or cleared by a pop read as zero
  assign out_push_o             = b_valid_q;
  assign out_item_o.status      = b_status_q;
  assign out_item_o.data_word   = (b_from_mem_q && b_hit_q) ? rdata_q : '0;
  assign out_item_o.slot_index  = b_slot_q;
  assign out_item_o.last_of_run = b_last_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= IDX_W'(DEPTH - 1))
    else $error("head index out of range");

  a_show_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_SHOW |-> cmd_chan_i.valid && cmd_chan_i.cmd.kind == cqe_pkg::CMD_SHOW)
    else $error("show command left the queue early");

  a_out_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> out_cnt_i < OCNT_W'(cqe_pkg::OUTQ_DEPTH))
    else $error("result queue overflow");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_ok |=> count_q == $past(count_q) - 1'b1)
    else $error("pop did not decrement the count");

endmodule

[src/circular_queue_engine.sv]
// Top level of the circular queue engine: front end, back end, result queue.
//
// Usage:
// - Input channel: in_item_i carries an opcode (push, pop, show) and a push
//   word. A transfer happens on a rising edge with push high and full low.
//   The unused opcode is taken and produces nothing.
// - Result channel: while empty is low, out_item_o holds the oldest result;
//   it is transferred on a rising edge with pop high.
// - Push and pop each give one result with a status; a pop also returns the
//   word it removed. Show gives DEPTH results, one per slot in storage order,
//   with last_of_run set on the final slot.
// - Each input passes the command queue and read stage into the result queue.
// - Throughput: push and pop sustain one item per cycle while the result
//   queue has room; a show holds the back end while it reads every slot.
// - A two-entry command queue and a four-entry result queue part the sides:
//   a stalled receiver fills the result queue, then the command queue, and
//   only then does full rise. Nothing is lost or repeated.
// - Reset clears head, count and the per-slot valid flags at once, so every
//   slot reads as zero straight away; there is no clearing pass.
module circular_queue_engine #(
  parameter int unsigned DEPTH = cqe_pkg::DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  cqe_pkg::in_item_t   in_item_i,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output cqe_pkg::out_item_t  out_item_o
);

  localparam int unsigned OCNT_W = $clog2(cqe_pkg::OUTQ_DEPTH + 1);

  cqe_pkg::cmd_chan_t  cmd_chan;
  logic                cmd_pop;
  logic                res_push;
  cqe_pkg::out_item_t  res_item;
  logic [OCNT_W-1:0]   res_cnt;

  // decode and buffer incoming transfers
  cqe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_item_i  (in_item_i),
    .full_o     (full),
    .cmd_chan_o (cmd_chan),
    .cmd_pop_i  (cmd_pop)
  );

  // queue state and slot memory; issues only when the result queue has room
  cqe_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_chan_i (cmd_chan),
    .cmd_pop_o  (cmd_pop),
    .out_cnt_i  (res_cnt),
    .out_push_o (res_push),
    .out_item_o (res_item)
  );

  // result queue decouples the back end from a stalling receiver
  cqe_fifo #(
    .ENTRIES (cqe_pkg::OUTQ_DEPTH),
    .item_t  (cqe_pkg::out_item_t)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .item_i  (res_item),
    .pop_i   (pop),
    .item_o  (out_item_o),
    .full_o  (),
    .empty_o (empty),
    .count_o (res_cnt)
  );

endmodule
